// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset guard.
`define GSRR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Same, on the block's own clock and reset names.
`define GSRR_CHECK(label, prop, msg) \
    `GSRR_ASSERT(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/gsrr_pkg.sv =====
// Shared types and constants of the grid rotator.
// No dependencies.
package gsrr_pkg;

    localparam int GRID_MAX_DEF = 64;

    localparam int CELL_W  = 13;
    localparam int COORD_W = 7;
    localparam int RAD_W   = 5;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0] GRID_SIZE_RST = 7'd64;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_ROTATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic DIR_CW  = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_CELL_RD,
        ST_CELL_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/grid_square_region_rotator_core.sv =====
// Top level of the square grid rotator: cell memory, sequencer, result register.
// Depends on gsrr_pkg and gsrr_addr_gen.
//
// Keeps a GRID_MAX x GRID_MAX grid of 13-bit cells in one single-port memory
// (one read or one write per cycle, registered read data). The side in use is
// the cfg register (reset 64, saturated to GRID_MAX). One request is worked at
// a time; s_ready is high only while the sequencer is idle, and a finished
// result sits in the m_ register so the next request can start while it waits.
// Work per request, set by the one memory port:
//   initialize  n*n cells, one written per cycle (n = side in use)
//   rotate      s = 2*radius+1: each group of four cells on a ring of the
//               s x s square takes four reads and four writes
//   read        one memory read; the registered data becomes the result
//   out-of-range, radius-zero and unused requests: no memory access
// The cells are not cleared at reset; a cell holds garbage until the first
// initialize writes it.
module grid_square_region_rotator_core #(
    parameter int GRID_MAX = gsrr_pkg::GRID_MAX_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config
    input  logic                         cfg_we,
    input  logic [gsrr_pkg::CFG_W-1:0]   cfg_wdata,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [gsrr_pkg::COORD_W-1:0] s_center_row,
    input  logic [gsrr_pkg::COORD_W-1:0] s_center_col,
    input  logic [gsrr_pkg::RAD_W-1:0]   s_radius,
    input  logic                         s_direction,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gsrr_pkg::CELL_W-1:0]  m_cell_value,
    output logic                         m_out_of_range
);
    localparam int AW    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int NW    = ($clog2(GRID_MAX+1) > 7) ? $clog2(GRID_MAX+1) : 7;
    localparam int CW    = NW + 1;
    localparam int MAW   = (GRID_MAX > 1) ? $clog2(GRID_MAX*GRID_MAX) : 1;
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int VW    = gsrr_pkg::CELL_W;

    gsrr_pkg::state_t state_reg, state_next;

    // latched request
    logic                        dir_reg;
    logic [gsrr_pkg::RAD_W-1:0]  rad_reg;
    logic [AW-1:0]               base_row_reg, base_col_reg;

    // loop counters: ring/column for rotate, row/column for initialize
    logic [NW-1:0]               idx_a_reg, idx_b_reg;
    logic [1:0]                  step_reg;
    logic [VW-1:0]               init_val_reg;

    // four-cell rotation buffer and read-data capture
    logic [VW-1:0]               v_reg [4];
    logic                        cap_valid_reg;
    logic [1:0]                  cap_idx_reg;

    logic [VW-1:0]               res_value_reg;
    logic                        res_oor_reg;

    logic                        m_valid_reg;
    logic [VW-1:0]               m_value_reg;
    logic                        m_oor_reg;

    logic [gsrr_pkg::CFG_W-1:0]  grid_size_reg;

    logic [VW-1:0]               mem [DEPTH];
    logic [VW-1:0]               rd_data_reg;

    // ---------------------------------------------------------------------
    // Side in use and request range checks
    // ---------------------------------------------------------------------
    logic [NW-1:0] n_side;
    logic [NW-1:0] n_m1;
    logic [CW-1:0] row_w, col_w, rad_w, n_w;
    logic          rot_ok, rd_ok;
    logic          accept;

    assign n_side = (NW'(grid_size_reg) > NW'(GRID_MAX)) ? NW'(GRID_MAX)
                                                         : NW'(grid_size_reg);
    assign n_m1   = n_side - NW'(1);

    assign row_w = CW'(s_center_row);
    assign col_w = CW'(s_center_col);
    assign rad_w = CW'(s_radius);
    assign n_w   = CW'(n_side);

    // whole square must sit within 1..n on both axes
    assign rot_ok = (row_w >= rad_w + CW'(1)) && (row_w + rad_w <= n_w) &&
                    (col_w >= rad_w + CW'(1)) && (col_w + rad_w <= n_w);
    assign rd_ok  = (row_w >= CW'(1)) && (row_w <= n_w) &&
                    (col_w >= CW'(1)) && (col_w <= n_w);

    assign accept = s_valid && s_ready;

    // ---------------------------------------------------------------------
    // Ring geometry. m = s-1; the four cells of one group are
    //   p0 (a,b)  p1 (m-b,a)  p2 (m-a,m-b)  p3 (b,m-a)
    // clockwise: new[pk] = old[pk+1]; counterclockwise: new[pk] = old[pk-1].
    // ---------------------------------------------------------------------
    logic [NW-1:0] m_span, ma, mb;
    logic          last_b, last_a, init_last_col, init_last_row;

    assign m_span = NW'({rad_reg, 1'b0});
    assign ma     = m_span - idx_a_reg;
    assign mb     = m_span - idx_b_reg;
    assign last_b = (idx_a_reg + idx_b_reg + NW'(1)) == m_span;
    assign last_a = (idx_a_reg + NW'(1)) == NW'(rad_reg);

    assign init_last_col = (idx_b_reg == n_m1);
    assign init_last_row = (idx_a_reg == n_m1);

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gsrr_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        gsrr_pkg::OP_INIT: begin
                            state_next = (n_side == '0) ? gsrr_pkg::ST_DONE
                                                        : gsrr_pkg::ST_INIT;
                        end
                        gsrr_pkg::OP_ROTATE: begin
                            state_next = (rot_ok && (s_radius != '0))
                                         ? gsrr_pkg::ST_ROT_RD : gsrr_pkg::ST_DONE;
                        end
                        gsrr_pkg::OP_READ: begin
                            state_next = rd_ok ? gsrr_pkg::ST_CELL_RD
                                               : gsrr_pkg::ST_DONE;
                        end
                        default: state_next = gsrr_pkg::ST_DONE;
                    endcase
                end
            end
            gsrr_pkg::ST_INIT: begin
                if (init_last_col && init_last_row) begin
                    state_next = gsrr_pkg::ST_DONE;
                end
            end
            gsrr_pkg::ST_ROT_RD: begin
                if (step_reg == 2'd3) begin
                    state_next = gsrr_pkg::ST_ROT_WR;
                end
            end
            gsrr_pkg::ST_ROT_WR: begin
                if (step_reg == 2'd3) begin
                    state_next = (last_b && last_a) ? gsrr_pkg::ST_DONE
                                                    : gsrr_pkg::ST_ROT_RD;
                end
            end
            gsrr_pkg::ST_CELL_RD:   state_next = gsrr_pkg::ST_CELL_WAIT;
            gsrr_pkg::ST_CELL_WAIT: state_next = gsrr_pkg::ST_DONE;
            gsrr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = gsrr_pkg::ST_IDLE;
                end
            end
            default: state_next = gsrr_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer outputs: memory control and address offsets
    // ---------------------------------------------------------------------
    logic [1:0]    pos_sel;
    logic [1:0]    step_p1;
    logic [NW-1:0] off_row, off_col;
    logic          mem_we;
    logic [VW-1:0] mem_wdata;
    logic          load_result;
    logic [MAW-1:0] mem_addr;

    assign step_p1 = step_reg + 2'd1;

    always_comb begin
        pos_sel     = step_reg;
        off_row     = '0;
        off_col     = '0;
        mem_we      = 1'b0;
        mem_wdata   = '0;
        load_result = 1'b0;
        case (state_reg)
            gsrr_pkg::ST_INIT: begin
                off_row   = idx_a_reg;
                off_col   = idx_b_reg;
                mem_we    = 1'b1;
                mem_wdata = init_val_reg;
            end
            gsrr_pkg::ST_ROT_RD: begin
                pos_sel = step_reg;
            end
            gsrr_pkg::ST_ROT_WR: begin
                mem_we = 1'b1;
                if (dir_reg == gsrr_pkg::DIR_CW) begin
                    pos_sel   = step_reg;
                    mem_wdata = v_reg[step_p1];
                end else begin
                    // write p1,p2,p3,p0 so the last-read value is used last
                    pos_sel   = step_p1;
                    mem_wdata = v_reg[step_reg];
                end
            end
            gsrr_pkg::ST_DONE: begin
                load_result = !m_valid_reg || m_ready;
            end
            default: ;
        endcase

        if ((state_reg == gsrr_pkg::ST_ROT_RD) || (state_reg == gsrr_pkg::ST_ROT_WR)) begin
            case (pos_sel)
                2'd0: begin off_row = idx_a_reg; off_col = idx_b_reg; end
                2'd1: begin off_row = mb;        off_col = idx_a_reg; end
                2'd2: begin off_row = ma;        off_col = mb;        end
                default: begin off_row = idx_b_reg; off_col = ma;     end
            endcase
        end
    end

    gsrr_addr_gen #(
        .GRID_MAX (GRID_MAX)
    ) u_addr (
        .base_row (base_row_reg),
        .base_col (base_col_reg),
        .off_row  (off_row),
        .off_col  (off_col),
        .addr     (mem_addr)
    );

    // ---------------------------------------------------------------------
    // Cell memory: one port, read data registered
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gsrr_pkg::ST_IDLE;
            grid_size_reg <= gsrr_pkg::GRID_SIZE_RST;
            m_valid_reg   <= 1'b0;
            cap_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                grid_size_reg <= cfg_wdata;
            end
            if (load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            cap_valid_reg <= (state_reg == gsrr_pkg::ST_ROT_RD);
        end
    end

    // ---------------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        cap_idx_reg <= step_reg;
        if (cap_valid_reg) begin
            v_reg[cap_idx_reg] <= rd_data_reg;
        end

        if (accept) begin
            dir_reg       <= s_direction;
            rad_reg       <= s_radius;
            idx_a_reg     <= '0;
            idx_b_reg     <= '0;
            step_reg      <= '0;
            init_val_reg  <= VW'(1);
            res_value_reg <= '0;
            res_oor_reg   <= ((s_operation == gsrr_pkg::OP_ROTATE) && !rot_ok) ||
                             ((s_operation == gsrr_pkg::OP_READ) && !rd_ok);
            case (s_operation)
                gsrr_pkg::OP_ROTATE: begin
                    base_row_reg <= AW'(row_w - rad_w - CW'(1));
                    base_col_reg <= AW'(col_w - rad_w - CW'(1));
                end
                gsrr_pkg::OP_READ: begin
                    base_row_reg <= AW'(row_w - CW'(1));
                    base_col_reg <= AW'(col_w - CW'(1));
                end
                default: begin
                    base_row_reg <= '0;
                    base_col_reg <= '0;
                end
            endcase
        end

        case (state_reg)
            gsrr_pkg::ST_INIT: begin
                init_val_reg <= init_val_reg + VW'(1);
                if (init_last_col) begin
                    idx_b_reg <= '0;
                    idx_a_reg <= idx_a_reg + NW'(1);
                end else begin
                    idx_b_reg <= idx_b_reg + NW'(1);
                end
            end
            gsrr_pkg::ST_ROT_RD: begin
                step_reg <= step_p1;
            end
            gsrr_pkg::ST_ROT_WR: begin
                step_reg <= step_p1;
                if (step_reg == 2'd3) begin
                    if (last_b) begin
                        idx_a_reg <= idx_a_reg + NW'(1);
                        idx_b_reg <= idx_a_reg + NW'(1);
                    end else begin
                        idx_b_reg <= idx_b_reg + NW'(1);
                    end
                end
            end
            gsrr_pkg::ST_CELL_WAIT: begin
                res_value_reg <= rd_data_reg;
            end
            default: ;
        endcase

        if (load_result) begin
            m_value_reg <= res_value_reg;
            m_oor_reg   <= res_oor_reg;
        end
    end

    assign s_ready        = (state_reg == gsrr_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_cell_value   = m_value_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

// ===== rtl/gsrr_addr_gen.sv =====
// Grid address unit: base corner plus in-square offset, to a flat cell index.
// Depends on nothing but its parameter; shared by every sequencer state.
module gsrr_addr_gen #(
    parameter int GRID_MAX = 64
) (
    input  logic [((GRID_MAX > 1) ? $clog2(GRID_MAX) : 1)-1:0] base_row,
    input  logic [((GRID_MAX > 1) ? $clog2(GRID_MAX) : 1)-1:0] base_col,
    input  logic [(($clog2(GRID_MAX+1) > 7) ? $clog2(GRID_MAX+1) : 7)-1:0] off_row,
    input  logic [(($clog2(GRID_MAX+1) > 7) ? $clog2(GRID_MAX+1) : 7)-1:0] off_col,
    output logic [((GRID_MAX > 1) ? $clog2(GRID_MAX*GRID_MAX) : 1)-1:0] addr
);
    localparam int AW  = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int NW  = ($clog2(GRID_MAX+1) > 7) ? $clog2(GRID_MAX+1) : 7;
    localparam int MAW = (GRID_MAX > 1) ? $clog2(GRID_MAX*GRID_MAX) : 1;

    logic [NW-1:0] row_sum;
    logic [NW-1:0] col_sum;
    logic [AW-1:0] row_idx;
    logic [AW-1:0] col_idx;

    assign row_sum = NW'(base_row) + off_row;
    assign col_sum = NW'(base_col) + off_col;
    assign row_idx = row_sum[AW-1:0];
    assign col_idx = col_sum[AW-1:0];

    // row-major flat index; a shift when GRID_MAX is a power of two
    assign addr = MAW'(MAW'(row_idx) * MAW'(GRID_MAX)) + MAW'(col_idx);

endmodule

// ===== rtl/gsrr_checker.sv =====
// Port-level checker for the grid rotator, bound to the top level.
// Depends on assert_macros.svh and gsrr_pkg.
`include "assert_macros.svh"

module gsrr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [gsrr_pkg::CELL_W-1:0] m_cell_value,
    input logic                        m_out_of_range
);

    `GSRR_CHECK(a_m_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    `GSRR_CHECK(a_m_stable, m_valid && !m_ready |=> $stable(m_cell_value) && $stable(m_out_of_range), "result changed while stalled")

    `GSRR_CHECK(a_oor_zero, m_valid && m_out_of_range |-> m_cell_value == '0, "flagged result carries a value")

    `GSRR_CHECK(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready right after a request")

endmodule

bind grid_square_region_rotator_core gsrr_checker u_gsrr_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for grid_square_region_rotator_core.
// Depends on gsrr_pkg and the core RTL; keeps its own model of the grid
// and checks every result against it.
`timescale 1ns / 1ps

module tb_top;

    localparam int GRID_MAX = gsrr_pkg::GRID_MAX_DEF;

    // Opcode and direction values the package does not name
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic       DIR_CCW   = 1'b1;

    // Hang guard on the whole run
    localparam int RUN_LIMIT_CYCLES = 5_000_000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PER_PHASE = 18;

    typedef struct packed {
        logic [1:0]                   op;
        logic [gsrr_pkg::COORD_W-1:0] row;
        logic [gsrr_pkg::COORD_W-1:0] col;
        logic [gsrr_pkg::RAD_W-1:0]   rad;
        logic                         dir;
    } grid_request_t;

    typedef struct packed {
        logic [gsrr_pkg::CELL_W-1:0] cell_value;
        logic                        out_of_range;
    } grid_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                         cfg_we    = 1'b0;
    logic [gsrr_pkg::CFG_W-1:0]   cfg_wdata = '0;

    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_operation    = gsrr_pkg::OP_INIT;
    logic [gsrr_pkg::COORD_W-1:0] s_center_row   = '0;
    logic [gsrr_pkg::COORD_W-1:0] s_center_col   = '0;
    logic [gsrr_pkg::RAD_W-1:0]   s_radius       = '0;
    logic                         s_direction    = gsrr_pkg::DIR_CW;

    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [gsrr_pkg::CELL_W-1:0]  m_cell_value;
    logic                         m_out_of_range;

    // Grid model: cell values, plus a flag per cell telling whether an
    // initialize has put a defined value there (the flag moves with rotations)
    logic [gsrr_pkg::CELL_W-1:0] grid_image [GRID_MAX][GRID_MAX];
    bit                          cell_known [GRID_MAX][GRID_MAX];
    logic [gsrr_pkg::CELL_W-1:0] turn_buf   [GRID_MAX][GRID_MAX];
    bit                          turn_known [GRID_MAX][GRID_MAX];
    int                          grid_side_reg;

    grid_result_t pending_results[$];

    // Idle control, changed per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int mismatch_count = 0;
    int results_seen   = 0;
    int requests_sent  = 0;
    int op_count [4];
    int side_min = GRID_MAX + 100;
    int side_max = -1;

    grid_square_region_rotator_core #(
        .GRID_MAX(GRID_MAX)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_center_row  (s_center_row),
        .s_center_col  (s_center_col),
        .s_radius      (s_radius),
        .s_direction   (s_direction),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cell_value  (m_cell_value),
        .m_out_of_range(m_out_of_range)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Side in use: register value saturated to the grid size
    function automatic int active_side();
        return (grid_side_reg > GRID_MAX) ? GRID_MAX : grid_side_reg;
    endfunction

    // Applies one request to the grid model and returns the result it owes
    function automatic grid_result_t predict_grid_op(grid_request_t rq);
        grid_result_t res;
        int n, row, col, rad, s, r0, c0, i, j;
        res = '0;
        n   = active_side();
        row = rq.row;
        col = rq.col;
        rad = rq.rad;
        case (rq.op)
            gsrr_pkg::OP_INIT: begin
                // Row-major numbering, 1-based, kept to cell width
                for (i = 0; i < n; i++)
                    for (j = 0; j < n; j++) begin
                        grid_image[i][j] = gsrr_pkg::CELL_W'(n * i + j + 1);
                        cell_known[i][j] = 1'b1;
                    end
            end
            gsrr_pkg::OP_ROTATE: begin
                if (row < rad + 1 || row + rad > n || col < rad + 1 || col + rad > n) begin
                    res.out_of_range = 1'b1;
                end else begin
                    s  = 2 * rad + 1;
                    r0 = row - rad - 1;
                    c0 = col - rad - 1;
                    for (i = 0; i < s; i++)
                        for (j = 0; j < s; j++) begin
                            turn_buf[i][j]   = grid_image[r0 + i][c0 + j];
                            turn_known[i][j] = cell_known[r0 + i][c0 + j];
                        end
                    for (i = 0; i < s; i++)
                        for (j = 0; j < s; j++) begin
                            if (rq.dir == gsrr_pkg::DIR_CW) begin
                                grid_image[r0 + i][c0 + j] = turn_buf[s - 1 - j][i];
                                cell_known[r0 + i][c0 + j] = turn_known[s - 1 - j][i];
                            end else begin
                                grid_image[r0 + i][c0 + j] = turn_buf[j][s - 1 - i];
                                cell_known[r0 + i][c0 + j] = turn_known[j][s - 1 - i];
                            end
                        end
                end
            end
            gsrr_pkg::OP_READ: begin
                if (row < 1 || row > n || col < 1 || col > n)
                    res.out_of_range = 1'b1;
                else
                    res.cell_value = grid_image[row - 1][col - 1];
            end
            default: ;  // unused opcode: no change, zero result
        endcase
        return res;
    endfunction

    // A read that lands on a never-initialized cell is off limits
    function automatic bit reads_unknown_cell(grid_request_t rq);
        int n;
        n = active_side();
        if (rq.op != gsrr_pkg::OP_READ) return 1'b0;
        if (rq.row < 1 || rq.row > n || rq.col < 1 || rq.col > n) return 1'b0;
        return !cell_known[rq.row - 1][rq.col - 1];
    endfunction

    function automatic grid_request_t make_request(logic [1:0] op, int row, int col,
                                                   int rad, logic dir);
        grid_request_t rq;
        rq.op  = op;
        rq.row = gsrr_pkg::COORD_W'(row);
        rq.col = gsrr_pkg::COORD_W'(col);
        rq.rad = gsrr_pkg::RAD_W'(rad);
        rq.dir = dir;
        return rq;
    endfunction

    // Random request: some initializes, mostly well-formed rotates and reads inside the grid,
    // with some full-range noise and unused opcodes mixed in
    function automatic grid_request_t random_request();
        grid_request_t rq;
        int n, pick, rad;
        n      = active_side();
        pick   = $urandom_range(99);
        rq.op  = OP_UNUSED;
        rq.row = gsrr_pkg::COORD_W'($urandom_range(127));
        rq.col = gsrr_pkg::COORD_W'($urandom_range(127));
        rq.rad = gsrr_pkg::RAD_W'($urandom_range(31));
        rq.dir = 1'($urandom_range(1));
        if (pick < 10) begin
            rq.op = gsrr_pkg::OP_INIT;
        end else if (pick < 50) begin
            rq.op = gsrr_pkg::OP_ROTATE;
            if (n >= 1) begin
                rad    = $urandom_range((n - 1) / 2);
                rq.rad = gsrr_pkg::RAD_W'(rad);
                rq.row = gsrr_pkg::COORD_W'($urandom_range(n - rad, rad + 1));
                rq.col = gsrr_pkg::COORD_W'($urandom_range(n - rad, rad + 1));
            end
        end else if (pick < 60) begin
            rq.op = gsrr_pkg::OP_ROTATE;
        end else if (pick < 90) begin
            rq.op = gsrr_pkg::OP_READ;
            if (n >= 1) begin
                rq.row = gsrr_pkg::COORD_W'($urandom_range(n, 1));
                rq.col = gsrr_pkg::COORD_W'($urandom_range(n, 1));
            end
        end else if (pick < 96) begin
            rq.op = gsrr_pkg::OP_READ;
        end
        // Never read undefined contents; initialize instead
        if (reads_unknown_cell(rq))
            rq.op = gsrr_pkg::OP_INIT;
        return rq;
    endfunction

    // Sends one request and records its expected result once accepted.
    // Called at a rising edge; valid stays high between back-to-back requests.
    task automatic send_request(input grid_request_t rq);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= rq.op;
        s_center_row <= rq.row;
        s_center_col <= rq.col;
        s_radius     <= rq.rad;
        s_direction  <= rq.dir;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_grid_op(rq));
        requests_sent++;
        op_count[rq.op]++;
    endtask

    // Drops valid and waits until every result is back; the block is then idle
    task automatic wait_grid_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Register write, only with the block idle
    task automatic set_grid_size(input int value);
        wait_grid_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= gsrr_pkg::CFG_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        grid_side_reg = value & ((1 << gsrr_pkg::CFG_W) - 1);
        if (active_side() < side_min) side_min = active_side();
        if (active_side() > side_max) side_max = active_side();
    endtask

    // Result side: random back-pressure, and every accepted result is
    // compared with the oldest expectation
    always @(posedge aclk) begin
        grid_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result value %0d oor %0b at %0t",
                             m_cell_value, m_out_of_range, $realtime);
            end else begin
                want = pending_results.pop_front();
                if (m_cell_value !== want.cell_value ||
                    m_out_of_range !== want.out_of_range) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: result %0d: expected value %0d oor %0b, got %0d oor %0b",
                                 results_seen, want.cell_value, want.out_of_range,
                                 m_cell_value, m_out_of_range);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Reset-value size: full-grid numbering, the corners, the largest
    // rotations, single-cell rotation, regions and cells off the grid,
    // and the unused opcode with every field at its maximum
    task automatic test_reset_size();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_request(make_request(gsrr_pkg::OP_INIT, 0, 0, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_READ, 1, 1, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_READ, 64, 64, 31, DIR_CCW));
        send_request(make_request(gsrr_pkg::OP_READ, 65, 1, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_READ, 0, 127, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(OP_UNUSED, 127, 127, 31, DIR_CCW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 32, 32, 31, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_READ, 1, 1, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 33, 33, 31, DIR_CCW));
        send_request(make_request(gsrr_pkg::OP_READ, 64, 2, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 64, 64, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 64, 64, 1, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 1, 1, 1, DIR_CCW));
    endtask

    // Register extremes: empty grid, oversized value saturating, the 1x1
    // grid, and a 3x3 grid turned both ways
    task automatic test_config_edges();
        set_grid_size(0);
        send_request(make_request(gsrr_pkg::OP_INIT, 0, 0, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_READ, 1, 1, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 1, 1, 0, gsrr_pkg::DIR_CW));
        set_grid_size(127);
        send_request(make_request(gsrr_pkg::OP_INIT, 0, 0, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_READ, 64, 64, 0, gsrr_pkg::DIR_CW));
        set_grid_size(1);
        send_request(make_request(gsrr_pkg::OP_INIT, 0, 0, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 1, 1, 0, DIR_CCW));
        send_request(make_request(gsrr_pkg::OP_READ, 2, 1, 0, gsrr_pkg::DIR_CW));
        set_grid_size(3);
        send_request(make_request(gsrr_pkg::OP_INIT, 0, 0, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 2, 2, 1, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_READ, 1, 3, 0, gsrr_pkg::DIR_CW));
        send_request(make_request(gsrr_pkg::OP_ROTATE, 2, 2, 1, DIR_CCW));
        send_request(make_request(gsrr_pkg::OP_READ, 3, 1, 0, gsrr_pkg::DIR_CW));
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct, input int side);
        int k;
        set_grid_size(side);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        send_request(make_request(gsrr_pkg::OP_INIT, $urandom_range(127), $urandom_range(127),
                                  $urandom_range(31), 1'($urandom_range(1))));
        for (k = 0; k < RANDOM_PER_PHASE; k++)
            send_request(random_request());
    endtask

    // Random traffic under each idling pattern; one phase on a large grid,
    // the rest small so rotations stay short
    task automatic test_random_traffic();
        run_random_phase(0, 0, $urandom_range(16, 1));
        run_random_phase(80, 0, $urandom_range(16, 1));
        run_random_phase(0, 80, $urandom_range(64, 17));
        run_random_phase(16, 16, $urandom_range(16, 1));
    endtask

    initial begin
        grid_side_reg = gsrr_pkg::GRID_SIZE_RST;
        side_min      = gsrr_pkg::GRID_SIZE_RST;
        side_max      = gsrr_pkg::GRID_SIZE_RST;
        foreach (cell_known[i, j]) cell_known[i][j] = 1'b0;
        foreach (op_count[i]) op_count[i] = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size();
        test_config_edges();
        test_random_traffic();

        wait_grid_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Coverage: %0d requests (%0d init, %0d rotate, %0d read, %0d unused), %0d results",
                 requests_sent, op_count[gsrr_pkg::OP_INIT], op_count[gsrr_pkg::OP_ROTATE],
                 op_count[gsrr_pkg::OP_READ], op_count[OP_UNUSED], results_seen);
        $display("Grid sides %0d..%0d, idle patterns none/source/sink/both, %0d mismatches",
                 side_min, side_max, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hang guard
    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge aclk);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
